// ----- sv/setc_pkg.sv -----
// Package for the sorted edge triangle counter.
// Holds store sizes, node width, operation codes and counter limits; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package setc_pkg;
    localparam int EDGE_DEPTH     = 16384;
    localparam int LOCATION_DEPTH = 8192;
    localparam int NODE_BITS      = 32;
    localparam int EIDX_BITS      = $clog2(EDGE_DEPTH);
    localparam int LIDX_BITS      = $clog2(LOCATION_DEPTH);
    localparam int VALUE_BITS     = 32;

    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD_EDGE = 2'd0;
    localparam t_op OP_LOAD_LOC  = 2'd1;
    localparam t_op OP_COUNT     = 2'd2;

    localparam logic [VALUE_BITS-1:0] COUNT_MAX = '1;
endpackage
`default_nettype wire

// ----- sv/setc_if.sv -----
// Handshake interfaces for request and result channels.
// Depends on setc_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface setc_req_if;
    import setc_pkg::*;
    logic                  valid;
    logic                  ready;
    t_op                   operation;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
    modport source (output valid, operation, first_value, second_value, input ready);
    modport sink   (input valid, operation, first_value, second_value, output ready);
endinterface

interface setc_rsp_if;
    import setc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] triangle_total;
    logic                  overflow_flag;
    modport source (output valid, triangle_total, overflow_flag, input ready);
    modport sink   (input valid, triangle_total, overflow_flag, output ready);
endinterface
`default_nettype wire

// ----- sv/sorted_edge_triangle_counter.sv -----
// Sorted edge triangle counter: two stores with a sequencer that searches and merges.
// Depends on setc_pkg and the interfaces in setc_if.sv.
// Load requests are accepted back to back while no result is waiting for the receiver.
// A count request walks every edge: it reads the edge, searches the location store and merges
// the two runs, each step waiting on its store read, then emits the result after the last edge.
// Reset clears the fill counts, the overflow flag and the sequencer; store contents
// stay undefined until written, and data read from unfilled entries is never used.
`timescale 1ns / 1ps
`default_nettype none
module sorted_edge_triangle_counter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    setc_req_if.sink    i_req,
    setc_rsp_if.source  o_rsp
);
    import setc_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EDGE_CHK = 7'b0000010,
        S_EDGE_WT  = 7'b0000100,
        S_SRCH     = 7'b0001000,
        S_SRCH_WT  = 7'b0010000,
        S_MERGE    = 7'b0100000,
        S_MERGE_WT = 7'b1000000
    } t_state;

    // Edge store: upper half is the first node, lower half the second node.
    logic [2*NODE_BITS-1:0]          edge_mem [EDGE_DEPTH];
    // Location store: upper part is the node id, lower part the first edge index.
    logic [NODE_BITS+VALUE_BITS-1:0] loc_mem  [LOCATION_DEPTH];

    t_state                 r_state;
    logic [EIDX_BITS:0]     r_efill;
    logic [LIDX_BITS:0]     r_lfill;
    logic                   r_ovf_seen;
    logic [EIDX_BITS:0]     r_i, r_pu, r_pv;
    logic [LIDX_BITS:0]     r_lo, r_hi, r_mid;
    logic [NODE_BITS-1:0]   r_u, r_v;
    logic [VALUE_BITS-1:0]  r_total;
    logic                   r_sat;
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_out_total;
    logic                   r_out_flag;

    // Registered read data of edge ports A and B and the location port.
    logic [2*NODE_BITS-1:0]          r_erd_a, r_erd_b;
    logic [NODE_BITS+VALUE_BITS-1:0] r_lrd;

    logic                   req_fire;
    logic [LIDX_BITS+1:0]   mid_sum;
    logic [LIDX_BITS:0]     mid;
    logic [VALUE_BITS-1:0]  efill_wide;
    logic [NODE_BITS-1:0]   nu, nv;

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign req_fire    = i_req.valid && i_req.ready;

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.triangle_total = r_out_total;
    assign o_rsp.overflow_flag  = r_out_flag;

    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi} - {{(LIDX_BITS+1){1'b0}}, 1'b1};
    assign mid        = mid_sum[LIDX_BITS+1:1];
    assign efill_wide = {{(VALUE_BITS-EIDX_BITS-1){1'b0}}, r_efill};
    assign nu         = r_erd_a[NODE_BITS-1:0];
    assign nv         = r_erd_b[NODE_BITS-1:0];

    // Store writes during loads.
    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.operation == OP_LOAD_EDGE && r_efill < EDGE_DEPTH) begin
            edge_mem[r_efill[EIDX_BITS-1:0]] <= {i_req.first_value[NODE_BITS-1:0],
                                                 i_req.second_value[NODE_BITS-1:0]};
        end
        if (req_fire && i_req.operation == OP_LOAD_LOC && r_lfill < LOCATION_DEPTH) begin
            loc_mem[r_lfill[LIDX_BITS-1:0]] <= {i_req.first_value[NODE_BITS-1:0],
                                               i_req.second_value};
        end
    end

    // Store reads. Port A serves the current edge and the u run, port B the v run.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EDGE_CHK) begin
            r_erd_a <= edge_mem[r_i[EIDX_BITS-1:0]];
        end else if (r_state == S_MERGE) begin
            r_erd_a <= edge_mem[r_pu[EIDX_BITS-1:0]];
        end
        if (r_state == S_MERGE) begin
            r_erd_b <= edge_mem[r_pv[EIDX_BITS-1:0]];
        end
        if (r_state == S_SRCH) begin
            r_lrd <= loc_mem[mid[LIDX_BITS-1:0]];
        end
    end

    // Sequencer: fill counts, search bounds, merge pointers and the count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_efill     <= '0;
            r_lfill     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        case (i_req.operation)
                            OP_LOAD_EDGE: begin
                                if (r_efill < EDGE_DEPTH) begin
                                    r_efill <= r_efill + 1'b1;
                                end else begin
                                    r_ovf_seen <= 1'b1;
                                end
                            end
                            OP_LOAD_LOC: begin
                                if (r_lfill < LOCATION_DEPTH) begin
                                    r_lfill <= r_lfill + 1'b1;
                                end else begin
                                    r_ovf_seen <= 1'b1;
                                end
                            end
                            OP_COUNT: begin
                                r_i     <= '0;
                                r_total <= '0;
                                r_sat   <= 1'b0;
                                r_state <= S_EDGE_CHK;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_EDGE_CHK: begin
                    if (r_i >= r_efill) begin
                        r_out_valid <= 1'b1;
                        r_out_total <= r_total;
                        r_out_flag  <= r_ovf_seen || r_sat;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_EDGE_WT;
                    end
                end
                S_EDGE_WT: begin
                    r_u     <= r_erd_a[2*NODE_BITS-1:NODE_BITS];
                    r_v     <= r_erd_a[NODE_BITS-1:0];
                    r_lo    <= '0;
                    r_hi    <= r_lfill;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_lo >= r_hi) begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EDGE_CHK;
                    end else begin
                        r_mid   <= mid;
                        r_state <= S_SRCH_WT;
                    end
                end
                S_SRCH_WT: begin
                    if (r_lrd[NODE_BITS+VALUE_BITS-1:VALUE_BITS] == r_v) begin
                        if (r_lrd[VALUE_BITS-1:0] >= efill_wide) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EDGE_CHK;
                        end else begin
                            r_pu    <= r_i;
                            r_pv    <= r_lrd[EIDX_BITS:0];
                            r_state <= S_MERGE;
                        end
                    end else if (r_lrd[NODE_BITS+VALUE_BITS-1:VALUE_BITS] > r_v) begin
                        r_hi    <= r_mid;
                        r_state <= S_SRCH;
                    end else begin
                        r_lo    <= r_mid + 1'b1;
                        r_state <= S_SRCH;
                    end
                end
                S_MERGE: begin
                    if (r_pu < r_efill && r_pv < r_efill) begin
                        r_state <= S_MERGE_WT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EDGE_CHK;
                    end
                end
                S_MERGE_WT: begin
                    if (r_erd_a[2*NODE_BITS-1:NODE_BITS] == r_u &&
                        r_erd_b[2*NODE_BITS-1:NODE_BITS] == r_v) begin
                        if (nu == nv) begin
                            if (r_total == COUNT_MAX) begin
                                r_sat <= 1'b1;
                            end else begin
                                r_total <= r_total + 1'b1;
                            end
                            r_pu <= r_pu + 1'b1;
                            r_pv <= r_pv + 1'b1;
                        end else if (nu < nv) begin
                            r_pu <= r_pu + 1'b1;
                        end else begin
                            r_pv <= r_pv + 1'b1;
                        end
                        r_state <= S_MERGE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EDGE_CHK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result never waits while a count is running.
    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending during count");

    // The fill counts never pass the store sizes.
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_efill <= EDGE_DEPTH) && (r_lfill <= LOCATION_DEPTH))
        else $error("fill count beyond store size");

    // A count request leads straight into the edge walk.
    a_count_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_fire && i_req.operation == OP_COUNT) |=> (r_state == S_EDGE_CHK))
        else $error("count request did not start the walk");

    // Merge pointers stay inside the filled store while a read is outstanding.
    a_merge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE_WT) |-> (r_pu < r_efill && r_pv < r_efill))
        else $error("merge read beyond fill");
endmodule
`default_nettype wire

// ----- tb/sv/tb_sorted_edge_triangle_counter.sv -----
// Self-checking bench for the sorted edge triangle counter: loads edge and location stores,
// requests counts and compares each emitted total and overflow flag with its own predictor.
// Depends on setc_pkg, the interfaces in setc_if.sv and the counter RTL.
`timescale 1ns / 1ps
module tb_sorted_edge_triangle_counter;
    import setc_pkg::*;

    typedef struct packed {
        t_op                   operation;
        logic [VALUE_BITS-1:0] first_value;
        logic [VALUE_BITS-1:0] second_value;
    } t_request;

    typedef struct packed {
        logic [VALUE_BITS-1:0] triangle_total;
        logic                  overflow_flag;
    } t_count_result;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    setc_req_if req_ch ();
    setc_rsp_if rsp_ch ();

    sorted_edge_triangle_counter dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // The predictor keeps its own copy of both stores and the sticky overflow bit.
    logic [NODE_BITS-1:0]  pred_edge_u [EDGE_DEPTH];
    logic [NODE_BITS-1:0]  pred_edge_v [EDGE_DEPTH];
    int unsigned           pred_edge_fill;
    logic [NODE_BITS-1:0]  pred_loc_id [LOCATION_DEPTH];
    logic [VALUE_BITS-1:0] pred_loc_first [LOCATION_DEPTH];
    int unsigned           pred_loc_fill;
    bit                    pred_overflow;

    t_request      pending_requests[$];
    t_count_result expected_counts[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned counts_checked;
    int unsigned requests_sent;
    bit          stimulus_done;
    bit          sink_hold;

    // Binary search over the location table, half-open interval as the hardware does it.
    function automatic bit search_location(input logic [NODE_BITS-1:0] node,
                                           output logic [VALUE_BITS-1:0] first_index);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = pred_loc_fill;
        first_index = '0;
        while (lo < hi) begin
            mid = (lo + hi - 1) >> 1;
            if (pred_loc_id[mid] == node) begin
                first_index = pred_loc_first[mid];
                return 1'b1;
            end else if (pred_loc_id[mid] > node) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_count_result tally_triangles();
        t_count_result         res;
        longint unsigned       pu;
        longint unsigned       pv;
        logic [VALUE_BITS-1:0] first_index;
        logic [NODE_BITS-1:0]  u;
        logic [NODE_BITS-1:0]  v;
        bit                    saturated;
        res = '0;
        saturated = 1'b0;
        for (int unsigned i = 0; i < pred_edge_fill; i++) begin
            u = pred_edge_u[i];
            v = pred_edge_v[i];
            if (!search_location(v, first_index)) continue;
            pu = i;
            pv = first_index;
            while (pu < pred_edge_fill && pv < pred_edge_fill &&
                   pred_edge_u[pu] == u && pred_edge_u[pv] == v) begin
                if (pred_edge_v[pu] == pred_edge_v[pv]) begin
                    if (res.triangle_total == COUNT_MAX) saturated = 1'b1;
                    else res.triangle_total++;
                    pu++;
                    pv++;
                end else if (pred_edge_v[pu] < pred_edge_v[pv]) begin
                    pu++;
                end else begin
                    pv++;
                end
            end
        end
        res.overflow_flag = pred_overflow | saturated;
        return res;
    endfunction

    function automatic void predict_request(input t_request r);
        case (r.operation)
            OP_LOAD_EDGE: begin
                if (pred_edge_fill < EDGE_DEPTH) begin
                    pred_edge_u[pred_edge_fill] = r.first_value[NODE_BITS-1:0];
                    pred_edge_v[pred_edge_fill] = r.second_value[NODE_BITS-1:0];
                    pred_edge_fill++;
                end else begin
                    pred_overflow = 1'b1;
                end
            end
            OP_LOAD_LOC: begin
                if (pred_loc_fill < LOCATION_DEPTH) begin
                    pred_loc_id[pred_loc_fill] = r.first_value[NODE_BITS-1:0];
                    pred_loc_first[pred_loc_fill] = r.second_value;
                    pred_loc_fill++;
                end else begin
                    pred_overflow = 1'b1;
                end
            end
            OP_COUNT: expected_counts.push_back(tally_triangles());
            default: ;
        endcase
    endfunction

    // Acceptance is taken at the rising edge, where the handshake actually happens.
    bit req_seen;
    always @(posedge i_clk) req_seen <= req_ch.valid && req_ch.ready;

    // Driver: presents one queued request at a time with a random gap before each.
    int unsigned drive_gap;
    bit          have_request;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            have_request = 1'b0;
            drive_gap = 0;
        end else begin
            if (req_seen) have_request = 1'b0;
            if (!have_request && drive_gap == 0 && pending_requests.size() > 0) begin
                t_request r;
                r = pending_requests.pop_front();
                req_ch.operation    <= r.operation;
                req_ch.first_value  <= r.first_value;
                req_ch.second_value <= r.second_value;
                req_ch.valid        <= 1'b1;
                have_request = 1'b1;
                drive_gap = $urandom_range(0, 19);
                if ($urandom_range(0, 3) == 0) drive_gap = 0;
            end else if (!have_request) begin
                req_ch.valid <= 1'b0;
                if (drive_gap > 0) drive_gap--;
            end
        end
    end

    // Sink side ready: random per-result wait, overridden by the long hold-off.
    int unsigned sink_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            sink_gap = 0;
        end else if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_ch.valid && rsp_ch.ready) begin
            sink_gap = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0) sink_gap = 0;
            rsp_ch.ready <= (sink_gap == 0);
        end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_ch.ready <= (sink_gap == 0);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Monitor: accepted requests feed the predictor, accepted results are checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (req_ch.valid && req_ch.ready) begin
                t_request r;
                r.operation    = req_ch.operation;
                r.first_value  = req_ch.first_value;
                r.second_value = req_ch.second_value;
                predict_request(r);
                requests_sent++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_count_result want;
                if (expected_counts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: total %0d flag %0b",
                                 rsp_ch.triangle_total, rsp_ch.overflow_flag);
                end else begin
                    want = expected_counts.pop_front();
                    counts_checked++;
                    if (want.triangle_total !== rsp_ch.triangle_total ||
                        want.overflow_flag !== rsp_ch.overflow_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected total %0d flag %0b, got %0d %0b",
                                     want.triangle_total, want.overflow_flag,
                                     rsp_ch.triangle_total, rsp_ch.overflow_flag);
                    end
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** sorted_edge_triangle_counter: FAILED **");
                $finish;
            end
        end
    end

    function automatic void push_request(input t_op op, input logic [31:0] a,
                                         input logic [31:0] b);
        t_request r;
        r.operation = op;
        r.first_value = a;
        r.second_value = b;
        pending_requests.push_back(r);
    endfunction

    // Small graph with random node labels: sorted edges, a location table
    // (usually matching the edges, sometimes with bad indexes or missing nodes), then a count.
    task automatic queue_graph(input int node_count, input bit noisy);
        logic [31:0] labels[$];
        logic [31:0] lab;
        logic [31:0] base;
        int          edge_index;
        int          first_of_node;
        base = $urandom();
        if ($urandom_range(0, 3) == 0) base = 32'hFFFF_FFFF - node_count * 4;
        for (int n = 0; n < node_count; n++) labels.push_back(base + n * $urandom_range(1, 3));
        edge_index = 0;
        for (int n = 0; n < node_count; n++) begin
            first_of_node = edge_index;
            for (int m = n + 1; m < node_count; m++) begin
                if ($urandom_range(0, 2) != 0) begin
                    push_request(OP_LOAD_EDGE, labels[n], labels[m]);
                    edge_index++;
                end
            end
            if (noisy && $urandom_range(0, 5) == 0) continue;
            lab = (noisy && $urandom_range(0, 7) == 0) ? $urandom() : first_of_node;
            if (first_of_node != edge_index || noisy)
                push_request(OP_LOAD_LOC, labels[n], lab);
        end
        if (noisy && $urandom_range(0, 2) == 0) push_request(OP_UNUSED, $urandom(), $urandom());
        push_request(OP_COUNT, $urandom(), $urandom());
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || expected_counts.size() > 0 || req_ch.valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_LOAD_EDGE;
        req_ch.first_value = '0;
        req_ch.second_value = '0;
        rsp_ch.ready = 1'b0;
        sink_hold = 1'b0;
        stimulus_done = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        counts_checked = 0;
        requests_sent = 0;
        pred_edge_fill = 0;
        pred_loc_fill = 0;
        pred_overflow = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: count on empty stores, an ignored code, one triangle on
        // extreme labels, an index beyond the fill, and a missing node.
        push_request(OP_COUNT, '0, '0);
        push_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(OP_LOAD_EDGE, 32'h0, 32'h1);
        push_request(OP_LOAD_EDGE, 32'h0, 32'hFFFF_FFFF);
        push_request(OP_LOAD_EDGE, 32'h1, 32'hFFFF_FFFF);
        push_request(OP_LOAD_LOC, 32'h0, 32'd0);
        push_request(OP_LOAD_LOC, 32'h1, 32'd2);
        push_request(OP_LOAD_LOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(OP_COUNT, '0, '0);
        push_request(OP_LOAD_EDGE, 32'hAAAA_AAAA, 32'h5555_5555);
        push_request(OP_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        // Random graphs; the stores keep growing, so the first graphs' nodes stay visible.
        for (int g = 0; g < 180; g++) begin
            if (g == 40) begin
                // The sender keeps offering while the receiver holds off for a long time.
                fork
                    begin
                        sink_hold = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        sink_hold = 1'b0;
                    end
                join_none
            end
            queue_graph($urandom_range(2, 5), $urandom_range(0, 4) == 0);
            if (g % 20 == 19) wait_drained();
        end
        wait_drained();

        stimulus_done = 1'b1;
        $display("covered %0d requests and %0d count results, edge fill %0d, location fill %0d",
                 requests_sent, counts_checked, pred_edge_fill, pred_loc_fill);
        if (mismatch_count == 0 && expected_counts.size() == 0) begin
            $display("** sorted_edge_triangle_counter: PASSED **");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("** sorted_edge_triangle_counter: FAILED **");
        end
        $finish;
    end
endmodule
